@@ sv/pdsw_pkg.sv @@
// shared types, constants and line address helpers for the pixel doubling screen writer
package pdsw_pkg;

    localparam int unsigned ROW_BYTES          = 16;
    localparam int unsigned DISPLAY_ROW_OFFSET = 32;

    localparam int unsigned COL_W      = 4;
    localparam int unsigned ROWS_W     = 7;
    localparam int unsigned LINE_W     = 8;
    localparam int unsigned ADDR_W     = 15;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned FIRST_W    = 6;
    localparam int unsigned CFG_W      = 7;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b1;

    localparam logic [ROWS_W-1:0] ROW_COUNT_RESET = 7'd64;
    localparam logic [COL_W-1:0]  LAST_COL        = COL_W'(ROW_BYTES - 1);
    localparam logic [LINE_W-1:0] ROW_OFFSET      = LINE_W'(DISPLAY_ROW_OFFSET);

    typedef struct packed {
        logic row_end;
        logic rect_end;
    } t_flags;

    // display line number to the y field of the interleaved address (address bits 12:5)
    function automatic logic [LINE_W-1:0] line_y(input logic [LINE_W-1:0] d);
        return {d[7:6], d[2:0], d[5:3]};
    endfunction

    // next display line in the interleaved layout
    function automatic logic [LINE_W-1:0] step_y(input logic [LINE_W-1:0] y);
        logic [LINE_W-1:0] inc;
        inc = y + 8'd1;
        if (y[5:3] == 3'b111) begin
            return inc & 8'hc7;
        end
        return y + 8'd8;
    endfunction

    // pack y field and column into a 15 bit screen address
    function automatic logic [ADDR_W-1:0] make_addr(input logic [LINE_W-1:0] y,
                                                    input logic [COL_W-1:0] col);
        return {1'b1, 1'b0, y, col, 1'b0};
    endfunction

endpackage

@@ sv/pdsw_addr_gen.sv @@
// column, row and line address tracking with row and rectangle end flags
module pdsw_addr_gen
    import pdsw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_step,
    input  logic                 i_frame_start,
    output logic [ADDR_W-1:0]    o_top_addr,
    output logic [ADDR_W-1:0]    o_bottom_addr,
    output t_flags               o_flags
);

    logic [FIRST_W-1:0] r_first_row;
    logic [ROWS_W-1:0]  r_row_count;
    logic [COL_W-1:0]   r_col,  n_col;
    logic [ROWS_W-1:0]  r_rows, n_rows;
    logic [LINE_W-1:0]  r_y,    n_y;

    logic [LINE_W-1:0]  start_y;
    logic [COL_W-1:0]   cur_col;
    logic [ROWS_W-1:0]  cur_rows;
    logic [ROWS_W-1:0]  next_rows;
    logic [LINE_W-1:0]  cur_y;
    logic [LINE_W-1:0]  bot_y;
    logic               row_end;
    logic               rect_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_row <= '0;
            r_row_count <= ROW_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FIRST_ROW: r_first_row <= i_cfg_wdata[FIRST_W-1:0];
                REG_ROW_COUNT: r_row_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        start_y   = line_y({1'b0, r_first_row, 1'b0} + ROW_OFFSET);
        cur_col   = i_frame_start ? '0 : r_col;
        cur_rows  = i_frame_start ? '0 : r_rows;
        cur_y     = i_frame_start ? start_y : r_y;
        bot_y     = step_y(cur_y);
        next_rows = cur_rows + 7'd1;
        row_end   = (cur_col >= LAST_COL);
        rect_end  = row_end && (next_rows == r_row_count);

        if (rect_end) begin
            n_col  = '0;
            n_rows = '0;
            n_y    = start_y;
        end else if (row_end) begin
            n_col  = '0;
            n_rows = next_rows;
            n_y    = step_y(bot_y);
        end else begin
            n_col  = cur_col + 4'd1;
            n_rows = cur_rows;
            n_y    = cur_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_rows <= '0;
            r_y    <= line_y(ROW_OFFSET);
        end else if (i_step) begin
            r_col  <= n_col;
            r_rows <= n_rows;
            r_y    <= n_y;
        end
    end

    assign o_top_addr       = make_addr(cur_y, cur_col);
    assign o_bottom_addr    = make_addr(bot_y, cur_col);
    assign o_flags.row_end  = row_end;
    assign o_flags.rect_end = rect_end;

endmodule

@@ sv/pdsw_doubler.sv @@
// doubles every pixel bit of a source byte into a 16 bit word
module pdsw_doubler
    import pdsw_pkg::*;
(
    input  logic [7:0]        i_byte,
    output logic [WORD_W-1:0] o_word
);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_word[2*i]   = i_byte[i];
            o_word[2*i+1] = i_byte[i];
        end
    end

endmodule

@@ sv/pixel_double_screen_writer.sv @@
// top level of the pixel doubling screen writer with its output register
// an accepted input transaction is registered and its result appears on the master side in the next cycle
// throughput: one byte per cycle while i_m_tready stays high, set by the single result register and its tready path
// o_s_tready is high whenever the result register is empty or being taken
// reset is synchronous active low: first_row 0, row_count 64, column and row count 0,
// line address at display row 32, result register empty
module pixel_double_screen_writer
    import pdsw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // src_byte
    input  logic                 i_s_tuser,   // frame_start
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [47:0]          o_m_tdata,   // top_address, bottom_address, doubled_word, pad
    output logic                 o_m_tlast,   // row_end
    output logic                 o_m_tuser    // rect_end
);

    logic                r_valid;
    logic [ADDR_W-1:0]   r_top;
    logic [ADDR_W-1:0]   r_bottom;
    logic [WORD_W-1:0]   r_word;
    t_flags              r_flags;

    logic                take;
    logic [ADDR_W-1:0]   top_addr;
    logic [ADDR_W-1:0]   bottom_addr;
    logic [WORD_W-1:0]   word;
    t_flags              flags;

    assign o_s_tready = !r_valid || i_m_tready;
    assign take       = i_s_tvalid && o_s_tready;

    pdsw_addr_gen u_addr_gen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_step        (take),
        .i_frame_start (i_s_tuser),
        .o_top_addr    (top_addr),
        .o_bottom_addr (bottom_addr),
        .o_flags       (flags)
    );

    pdsw_doubler u_doubler (
        .i_byte (i_s_tdata),
        .o_word (word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_top    <= top_addr;
            r_bottom <= bottom_addr;
            r_word   <= word;
            r_flags  <= flags;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {2'b00, r_word, r_bottom, r_top};
    assign o_m_tlast  = r_flags.row_end;
    assign o_m_tuser  = r_flags.rect_end;

endmodule

@@ verif/pdsw_checker.sv @@
// transaction checker for the pixel doubling screen writer: predicts and compares screen writes
module pdsw_checker
    import pdsw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [7:0]           i_s_tdata,   // src_byte
    input  logic                 i_s_tuser,   // frame_start
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [47:0]          i_m_tdata,   // top_address, bottom_address, doubled_word, pad
    input  logic                 i_m_tlast,   // row_end
    input  logic                 i_m_tuser,   // rect_end
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [ADDR_W-1:0] top_addr;
        logic [ADDR_W-1:0] bottom_addr;
        logic [WORD_W-1:0] word;
        logic              row_end;
        logic              rect_end;
    } t_screen_write;

    t_screen_write pending_writes[$];

    logic [FIRST_W-1:0] first_row;
    logic [ROWS_W-1:0]  row_count;
    logic [COL_W-1:0]   column;
    logic [ROWS_W-1:0]  rows_done;
    logic [15:0]        line_addr;

    // address of the first byte of display line d
    function automatic logic [15:0] line_base(input logic [7:0] d);
        logic [7:0] hi;
        hi = 8'h40 | ((d >> 3) & 8'h18) | (d & 8'h07);
        return {hi, (d << 2) & 8'he0};
    endfunction

    // same column one display line further down
    function automatic logic [15:0] line_below(input logic [15:0] a);
        logic [7:0] y;
        y = a[12:5];
        if (y[5:3] == 3'b111) begin
            y = (y + 8'd1) & 8'hc7;
        end else begin
            y = y + 8'd8;
        end
        return 16'h4000 | {3'b000, y, a[4:0]};
    endfunction

    function automatic logic [WORD_W-1:0] double_pixels(input logic [7:0] b);
        logic [WORD_W-1:0] w;
        for (int i = 0; i < 8; i++) begin
            w[2*i]   = b[i];
            w[2*i+1] = b[i];
        end
        return w;
    endfunction

    task restart_rect();
        logic [7:0] start_line;
        start_line = {1'b0, first_row, 1'b0} + 8'(DISPLAY_ROW_OFFSET);
        column     = '0;
        rows_done  = '0;
        line_addr  = line_base(start_line);
    endtask

    task compare_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            o_fail_count++;
        end
    endtask

    task predict_write(input logic [7:0] src, input logic frame_start);
        t_screen_write     w;
        logic [15:0]       offset;
        logic [ROWS_W-1:0] next_rows;
        if (frame_start) begin
            restart_rect();
        end
        offset        = {11'd0, column, 1'b0};
        w.top_addr    = ADDR_W'(line_addr + offset);
        w.bottom_addr = ADDR_W'(line_below(line_addr) + offset);
        w.word        = double_pixels(src);
        w.row_end     = (column >= COL_W'(ROW_BYTES - 1));
        w.rect_end    = 1'b0;
        if (w.row_end) begin
            next_rows  = rows_done + 7'd1;
            w.rect_end = (next_rows == row_count);
            if (w.rect_end) begin
                restart_rect();
            end else begin
                column    = '0;
                rows_done = next_rows;
                line_addr = line_below(line_below(line_addr));
            end
        end else begin
            column = column + 4'd1;
        end
        pending_writes.push_back(w);
    endtask

    always @(posedge i_clk) begin
        t_screen_write want;
        if (!i_rst_n) begin
            first_row    = '0;
            row_count    = ROW_COUNT_RESET;
            restart_rect();
            pending_writes.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_writes.size() == 0) begin
                    $error("result transaction with nothing expected: tdata %h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = pending_writes.pop_front();
                    compare_field("top_address", 16'(want.top_addr), 16'(i_m_tdata[14:0]));
                    compare_field("bottom_address", 16'(want.bottom_addr),
                                  16'(i_m_tdata[29:15]));
                    compare_field("doubled_word", want.word, i_m_tdata[45:30]);
                    compare_field("row_end", 16'(want.row_end), 16'(i_m_tlast));
                    compare_field("rect_end", 16'(want.rect_end), 16'(i_m_tuser));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_write(i_s_tdata, i_s_tuser);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FIRST_ROW: first_row = i_cfg_wdata[FIRST_W-1:0];
                    REG_ROW_COUNT: row_count = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        o_pending = pending_writes.size();
    end

endmodule

@@ verif/testbench.sv @@
// testbench top for the pixel doubling screen writer: clock, reset, stimulus and verdict
module testbench;
    import pdsw_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam logic [16:0][7:0] EDGE_BYTES = {
        8'hff, 8'h88, 8'h11, 8'he7, 8'h18, 8'hc3, 8'h3c, 8'hfe, 8'h7f,
        8'h0f, 8'hf0, 8'h55, 8'haa, 8'h01, 8'h80, 8'hff, 8'h00
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [47:0]          m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    int fail_count;
    int pending;
    int tx_mode     = 0;
    int rx_mode     = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    int idle_cycles = 0;

    pixel_double_screen_writer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .o_m_tuser   (m_tuser)
    );

    pdsw_checker u_screen_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // receiver stall pattern
    always @(negedge clk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            case (rx_mode)
                1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
                2: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 30);
                default: ;
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task send_byte(input logic [7:0] src, input logic frame_start);
        int gap;
        if (tx_mode != 0 && burst_left == 0) begin
            case (tx_mode)
                1: begin
                    gap        = $urandom_range(1, 3);
                    burst_left = $urandom_range(1, 8);
                end
                2: begin
                    gap        = $urandom_range(1, 12);
                    burst_left = $urandom_range(4, 32);
                end
                default: begin
                    gap        = 1;
                    burst_left = 1;
                end
            endcase
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= src;
        s_tuser  <= frame_start;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        if (burst_left > 0) burst_left--;
    endtask

    task wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
    endtask

    // which: 0 both registers, 1 first_row only, 2 row_count only
    task program_rect(input logic [6:0] first_val, input logic [6:0] count_val, input int which);
        if (which != 2) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= REG_FIRST_ROW;
            cfg_wdata <= first_val;
            @(negedge clk);
        end
        if (which != 1) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= REG_ROW_COUNT;
            cfg_wdata <= count_val;
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int n_items;
        int drain_at;
        logic [6:0] first_val;
        logic [6:0] count_val;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, start of a frame
        send_byte(EDGE_BYTES[0], 1'b1);
        for (int i = 1; i < 4; i++) send_byte(EDGE_BYTES[i], 1'b0);
        wait_drained();

        // one-row rectangle at the last source row, then wrap and a mid-row restart
        program_rect(7'h7f, 7'd1, 0);
        send_byte(EDGE_BYTES[0], 1'b1);
        for (int i = 1; i < 17; i++) send_byte(EDGE_BYTES[i], 1'b0);
        send_byte(8'h5a, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 3)
                0: first_val = 7'd0;
                1: first_val = 7'h7f;
                default: first_val = 7'($urandom_range(0, 127));
            endcase
            case (ph)
                1: count_val = 7'd64;
                2: count_val = 7'd127;
                default: count_val = 7'($urandom_range(1, 6));
            endcase
            program_rect(first_val, count_val, (ph < 3) ? 0 : $urandom_range(0, 2));
            tx_mode  = ph % 4;
            rx_mode  = (ph + 1) % 3;
            n_items  = $urandom_range(40, 70);
            drain_at = $urandom_range(20, n_items - 20);
            send_byte(random_byte(), 1'b1);
            for (int i = 1; i < n_items; i++) begin
                if (i == drain_at) wait_drained();
                send_byte(random_byte(), ($urandom_range(0, 24) == 0));
            end
            wait_drained();
        end

        // 128-row rectangle from the last source row, lines wrap past the display
        program_rect(7'd63, 7'd0, 0);
        tx_mode = 0;
        rx_mode = 1;
        send_byte(random_byte(), 1'b1);
        for (int i = 1; i < 52 * ROW_BYTES + 3; i++) send_byte(random_byte(), 1'b0);

        wait_drained();
        repeat (4) @(posedge clk);
        if (pending != 0) begin
            $error("%0d expected results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/pdsw_pkg.sv
sv/pdsw_addr_gen.sv
sv/pdsw_doubler.sv
sv/pixel_double_screen_writer.sv
verif/pdsw_checker.sv
verif/testbench.sv
